/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define FPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/fps_pkg.sv */
// ---------------------------------------------------------------------------
// Frame pacing scheduler package
// Widths, status codes and divider request/response types.
// ---------------------------------------------------------------------------
package fps_pkg;

  localparam int TimeW   = 40;
  localparam int RelW    = 48;
  localparam int AvgW    = 32;
  localparam int GapW    = 24;
  localparam int PendW   = 10;
  localparam int FracW   = 8;

  // numerator avg*(L-1) + gap_q stays below 2^41 for L up to 256
  localparam int DivW    = 41;
  localparam int DvsW    = 10;
  localparam int DivCntW = $clog2(DivW);

  localparam logic [GapW-1:0] MaxGapRst = 24'd10000000;

  typedef enum logic [1:0] {
    StReject   = 2'd0,
    StOnSched  = 2'd1,
    StCatchUp  = 2'd2,
    StLate     = 2'd3
  } status_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

/* rtl/core/fps_if.sv */
// ---------------------------------------------------------------------------
// Frame pacing scheduler channels
// Valid/ready interfaces for frame words and result words.
// ---------------------------------------------------------------------------
interface fps_in_if;
  logic                         valid;
  logic                         ready;
  logic [fps_pkg::TimeW-1:0]    frame_time_us;
  logic [fps_pkg::TimeW-1:0]    now_us;
  logic [fps_pkg::PendW-1:0]    pending_frames;

  modport source (output valid, frame_time_us, now_us, pending_frames, input ready);
  modport sink   (input valid, frame_time_us, now_us, pending_frames, output ready);
endinterface

interface fps_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [fps_pkg::TimeW-1:0]    wait_us;
  logic [fps_pkg::AvgW-1:0]     smoothed_period;

  modport source (output valid, status, wait_us, smoothed_period, input ready);
  modport sink   (input valid, status, wait_us, smoothed_period, output ready);
endinterface

/* rtl/core/frame_pacing_scheduler_top.sv */
// ---------------------------------------------------------------------------
// Frame pacing scheduler
// Smooths the frame period, schedules frame release and reports the wait.
// ---------------------------------------------------------------------------
//  channel   dir  handshake     word
//  in_i      in   valid/ready   frame_time_us, now_us, pending_frames
//  out_o     out  valid/ready   status, wait_us, smoothed_period
//  cfg       in   cfg_we_i      max_gap_us (cfg_wdata_i)
//
//  A result word passes check, multiply, filter divide, compare, update and
//  finish; an early frame with more than one frame queued adds the catch-up
//  divide; a rejected gap goes from check to finish. The 41-step serial
//  divider runs for the filter and again for catch-up. in_i.ready is high
//  only in idle; a waiting result word holds the next frame in its last state
//  until out_o takes it. Reset clears the schedule, period and last timestamp.
// ---------------------------------------------------------------------------
module frame_pacing_scheduler_top #(
  parameter int FILTER_LENGTH = 30
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [fps_pkg::GapW-1:0]  cfg_wdata_i,
  fps_in_if.sink                    in_i,
  fps_out_if.source                 out_o
);

  localparam logic [fps_pkg::DvsW-1:0] LenDiv = fps_pkg::DvsW'(FILTER_LENGTH);
  localparam logic [fps_pkg::DvsW-1:0] LenM1  = fps_pkg::DvsW'(FILTER_LENGTH - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL, S_DIVA_GO, S_DIVA_WAIT, S_CMP,
    S_DIVP_GO, S_DIVP_WAIT, S_UPD, S_FINISH
  } state_e;

  state_e                       state_q;
  logic [fps_pkg::GapW-1:0]     max_gap_q;
  logic [fps_pkg::TimeW-1:0]    ftime_q;
  logic [fps_pkg::TimeW-1:0]    now_q;
  logic [fps_pkg::PendW-1:0]    pend_q;
  logic [fps_pkg::TimeW-1:0]    last_q;
  logic [fps_pkg::AvgW-1:0]     avg_q;
  logic [fps_pkg::RelW-1:0]     rel_q;
  logic [fps_pkg::GapW-1:0]     gap_q;
  logic [fps_pkg::DivW-1:0]     acc_q;
  logic [fps_pkg::AvgW-1:0]     add_q;
  fps_pkg::status_e             status_q;
  logic [fps_pkg::TimeW-1:0]    wait_q;

  logic                         out_valid_q;
  logic [1:0]                   out_status_q;
  logic [fps_pkg::TimeW-1:0]    out_wait_q;
  logic [fps_pkg::AvgW-1:0]     out_avg_q;

  fps_pkg::div_req_t            div_req;
  fps_pkg::div_rsp_t            div_rsp;

  logic [fps_pkg::TimeW:0]      diff;
  logic                         gap_ok;
  logic [fps_pkg::AvgW-1:0]     gap_sh;
  logic [fps_pkg::RelW-1:0]     now_sh;
  logic [fps_pkg::RelW-1:0]     ahead;
  logic [fps_pkg::DivW-1:0]     prod;
  logic [fps_pkg::RelW:0]       sum;
  logic                         in_fire;
  logic                         out_free;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    diff   = {1'b0, ftime_q} - {1'b0, last_q};
    gap_ok = (ftime_q > last_q) &&
             (diff[fps_pkg::TimeW-1:0] <= fps_pkg::TimeW'(max_gap_q));
    gap_sh = {gap_q, {fps_pkg::FracW{1'b0}}};
    now_sh = {now_q, {fps_pkg::FracW{1'b0}}};
    ahead  = rel_q - now_sh;
    prod   = fps_pkg::DivW'(avg_q) * fps_pkg::DivW'(LenM1) + fps_pkg::DivW'(gap_sh);
    sum    = {1'b0, rel_q} + (fps_pkg::RelW + 1)'(add_q);
  end

  always_comb begin
    div_req.start    = (state_q == S_DIVA_GO) || (state_q == S_DIVP_GO);
    div_req.dividend = (state_q == S_DIVA_GO) ? acc_q : fps_pkg::DivW'(avg_q);
    div_req.divisor  = (state_q == S_DIVA_GO) ? LenDiv : pend_q;
  end

  fps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_gap_q    <= fps_pkg::MaxGapRst;
      ftime_q      <= '0;
      now_q        <= '0;
      pend_q       <= '0;
      last_q       <= '0;
      avg_q        <= '0;
      rel_q        <= '0;
      gap_q        <= '0;
      acc_q        <= '0;
      add_q        <= '0;
      status_q     <= fps_pkg::StReject;
      wait_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_wait_q   <= '0;
      out_avg_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_gap_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ftime_q <= in_i.frame_time_us;
            now_q   <= in_i.now_us;
            pend_q  <= in_i.pending_frames;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          last_q <= ftime_q;
          wait_q <= '0;
          if (gap_ok) begin
            gap_q <= diff[fps_pkg::GapW-1:0];
            if (avg_q == '0) begin
              avg_q <= {diff[fps_pkg::GapW-1:0], {fps_pkg::FracW{1'b0}}};
            end
            state_q <= S_MUL;
          end else begin
            status_q <= fps_pkg::StReject;
            state_q  <= S_FINISH;
          end
        end
        S_MUL: begin
          acc_q   <= prod;
          state_q <= S_DIVA_GO;
        end
        S_DIVA_GO: begin
          state_q <= S_DIVA_WAIT;
        end
        S_DIVA_WAIT: begin
          if (div_rsp.done) begin
            avg_q   <= div_rsp.quot[fps_pkg::AvgW-1:0];
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          if (now_sh < rel_q) begin
            wait_q <= ahead[fps_pkg::RelW-1:fps_pkg::FracW];
            if (pend_q <= fps_pkg::PendW'(1)) begin
              status_q <= fps_pkg::StOnSched;
              add_q    <= avg_q;
              state_q  <= S_UPD;
            end else begin
              status_q <= fps_pkg::StCatchUp;
              state_q  <= S_DIVP_GO;
            end
          end else begin
            status_q <= fps_pkg::StLate;
            rel_q    <= now_sh;
            add_q    <= avg_q;
            state_q  <= S_UPD;
          end
        end
        S_DIVP_GO: begin
          state_q <= S_DIVP_WAIT;
        end
        S_DIVP_WAIT: begin
          if (div_rsp.done) begin
            add_q   <= div_rsp.quot[fps_pkg::AvgW-1:0];
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          rel_q   <= sum[fps_pkg::RelW] ? '1 : sum[fps_pkg::RelW-1:0];
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_wait_q   <= wait_q;
            out_avg_q    <= avg_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready            = (state_q == S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.wait_us         = out_wait_q;
  assign out_o.smoothed_period = out_avg_q;

`include "assert_macros.svh"

  `FPS_ASSERT_SAME(a_no_wait_rej_late,
    out_o.valid && (out_o.status == fps_pkg::StReject || out_o.status == fps_pkg::StLate),
    out_o.wait_us == '0, "wait reported on rejected or late word")
  `FPS_ASSERT_SAME(a_period_nonzero,
    out_o.valid && out_o.status != fps_pkg::StReject,
    out_o.smoothed_period != '0, "zero period on accepted gap")
  `FPS_ASSERT_SAME(a_div_done_expected, div_rsp.done,
    state_q == S_DIVA_WAIT || state_q == S_DIVP_WAIT, "divider done while not waiting")
  `FPS_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_i.ready, "ready right after accept")

endmodule

/* rtl/core/fps_div.sv */
// ---------------------------------------------------------------------------
// Frame pacing serial divider
// Restoring unsigned divider, one quotient bit per cycle, DivW quotient bits.
// ---------------------------------------------------------------------------
module fps_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fps_pkg::div_req_t req_i,
  output fps_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [fps_pkg::DivCntW-1:0]   cnt_q;
  logic [fps_pkg::DvsW-1:0]      rem_q;
  logic [fps_pkg::DvsW-1:0]      dvs_q;
  logic [fps_pkg::DivW-1:0]      quo_q;

  logic [fps_pkg::DvsW:0]        trial;
  logic                          ge;
  logic [fps_pkg::DvsW-1:0]      rem_d;

  always_comb begin
    trial = {rem_q, quo_q[fps_pkg::DivW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? fps_pkg::DvsW'(trial - {1'b0, dvs_q}) : trial[fps_pkg::DvsW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= fps_pkg::DivCntW'(fps_pkg::DivW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[fps_pkg::DivW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// Frame pacing scheduler testbench
// A directed table walks rejects, late and early frames, catch-up steps and a
// saturated schedule. Six phases of random frames follow, one per gap limit,
// with most frames built around the predicted schedule. Every result word is
// checked field by field against a scoreboard fed by typed table rows or by a
// local model of the period filter and the release schedule.
// ----------------------------------------------------------------------------
module tb;
  import fps_pkg::*;

  localparam int FilterLen = 30;
  localparam int NumPhases = 6;
  localparam int PhaseItems = 310;
  localparam int PressurePhase = 2;
  localparam int HoldOff = 1500;
  localparam int CfgSettle = 100;
  localparam int DrainCycles = 200;
  localparam int Limit = 3000000;
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [RelW-1:0] RelMax = '1;

  typedef struct packed {
    status_e         status;
    logic [TimeW-1:0] wait_us;
    logic [AvgW-1:0]  period;
  } pace_word_t;

  typedef struct packed {
    logic [TimeW-1:0] ft;
    logic [TimeW-1:0] now;
    logic [PendW-1:0] pend;
    logic             typed;
    pace_word_t       want;
  } plan_row_t;

  typedef enum logic [1:0] {
    RdyOpen,
    RdyMostly,
    RdyHalf,
    RdySparse
  } ready_mode_e;

  localparam int NumPlan = 16;
  localparam plan_row_t Plan [NumPlan] = '{
    '{40'd0,        40'd0,          10'd0,    1'b1, '{StReject,  40'd0,    32'd0}},
    '{40'd1000,     40'd0,          10'd0,    1'b1, '{StLate,    40'd0,    32'd256000}},
    '{40'd2000,     40'd1000,       10'd1,    1'b1, '{StLate,    40'd0,    32'd256000}},
    '{40'd3000,     40'd0,          10'd1,    1'b1, '{StOnSched, 40'd2000, 32'd256000}},
    '{40'd4000,     40'd0,          10'd4,    1'b1, '{StCatchUp, 40'd3000, 32'd256000}},
    '{40'd4000,     40'd0,          10'd2,    1'b1, '{StReject,  40'd0,    32'd256000}},
    '{40'd3999,     40'd0,          10'd0,    1'b1, '{StReject,  40'd0,    32'd256000}},
    '{40'd10003999, 40'd0,          10'd0,    1'b0, '0},
    '{40'd20004000, 40'd0,          10'd1,    1'b0, '0},
    '{40'd20004001, TimeMax,        10'd1023, 1'b0, '0},
    '{40'd20004002, 40'd0,          10'd1023, 1'b0, '0},
    '{40'd20004003, 40'd0,          10'd2,    1'b0, '0},
    '{40'd20004004, 40'd0,          10'd0,    1'b0, '0},
    '{TimeMax,      TimeMax,        10'd1023, 1'b0, '0},
    '{40'd0,        40'd0,          10'd0,    1'b0, '0},
    '{40'd5000,     TimeMax - 40'd1, 10'd3,   1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [GapW-1:0] cfg_wdata_i;

  fps_in_if  frame_ch ();
  fps_out_if release_ch ();

  frame_pacing_scheduler_top #(
    .FILTER_LENGTH(FilterLen)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (frame_ch),
    .out_o      (release_ch)
  );

  always #1 clk_i = ~clk_i;

  // model state
  logic [GapW-1:0]  sched_max_gap = MaxGapRst;
  logic [TimeW-1:0] sched_last_ft = '0;
  logic [AvgW-1:0]  sched_avg = '0;
  logic [RelW-1:0]  sched_next_rel = '0;

  pace_word_t predicted_releases[$];
  int mismatches = 0;
  int frames_sent = 0;
  int limits_written = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int burst_left = 0;
  int cycles = 0;
  bit hold_off_req = 1'b0;

  function automatic pace_word_t pace_frame(input logic [TimeW-1:0] ft,
                                            input logic [TimeW-1:0] now,
                                            input logic [PendW-1:0] pend);
    pace_word_t w;
    logic [63:0] gap_q, now_q, advance, sum;
    w.status = StReject;
    w.wait_us = '0;
    if (ft > sched_last_ft && (ft - sched_last_ft) <= sched_max_gap) begin
      gap_q = 64'(ft - sched_last_ft) << FracW;
      now_q = 64'(now) << FracW;
      if (sched_avg == '0) begin
        sched_avg = gap_q[AvgW-1:0];
      end
      sched_avg = AvgW'((64'(sched_avg) * 64'(FilterLen - 1) + gap_q) / 64'(FilterLen));
      if (now_q < 64'(sched_next_rel)) begin
        w.wait_us = TimeW'((64'(sched_next_rel) - now_q) >> FracW);
        if (pend <= 10'd1) begin
          advance = 64'(sched_avg);
          w.status = StOnSched;
        end else begin
          advance = 64'(sched_avg) / 64'(pend);
          w.status = StCatchUp;
        end
        sum = 64'(sched_next_rel) + advance;
      end else begin
        sum = now_q + 64'(sched_avg);
        w.status = StLate;
      end
      sched_next_rel = (sum > 64'(RelMax)) ? RelMax : sum[RelW-1:0];
    end
    sched_last_ft = ft;
    w.period = sched_avg;
    return w;
  endfunction

  task automatic offer_frame(input logic [TimeW-1:0] ft, input logic [TimeW-1:0] now,
                             input logic [PendW-1:0] pend, input logic typed,
                             input pace_word_t typed_word);
    pace_word_t w;
    frame_ch.valid <= 1'b1;
    frame_ch.frame_time_us <= ft;
    frame_ch.now_us <= now;
    frame_ch.pending_frames <= pend;
    @(posedge clk_i);
    while (!frame_ch.ready) @(posedge clk_i);
    w = pace_frame(ft, now, pend);
    predicted_releases.push_back(typed ? typed_word : w);
    frames_sent++;
  endtask

  task automatic sender_pause(input bit gaps_on);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      if (gaps_on) begin
        frame_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_max_gap(input logic [GapW-1:0] value);
    while (predicted_releases.size() != 0) @(posedge clk_i);
    repeat (CfgSettle) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sched_max_gap = value;
    limits_written++;
  endtask

  // mostly frames with a legal gap and a time near the predicted schedule
  task automatic draw_frame(output logic [TimeW-1:0] ft, output logic [TimeW-1:0] now,
                            output logic [PendW-1:0] pend);
    logic [63:0] sched, spread, x;
    int unsigned r, lim;
    r = $urandom_range(0, 99);
    lim = (sched_max_gap < 24'd20000) ? sched_max_gap : 20000;
    if (r < 70) begin
      ft = sched_last_ft + TimeW'($urandom_range(1, lim));
    end else if (r < 80) begin
      ft = sched_last_ft + TimeW'($urandom_range(1, sched_max_gap));
    end else if (r < 85) begin
      ft = sched_last_ft + TimeW'(sched_max_gap);
    end else if (r < 90) begin
      ft = sched_last_ft + TimeW'(sched_max_gap) + 40'd1;
    end else if (r < 93) begin
      ft = sched_last_ft;
    end else begin
      ft = {8'($urandom), 32'($urandom)};
    end
    sched = 64'(sched_next_rel) >> FracW;
    spread = 64'(sched_avg >> FracW) + 64'd2;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      now = sched[TimeW-1:0];
    end else if (r <= 6) begin
      x = 64'($urandom_range(0, 32'(3 * spread)));
      now = (x > sched) ? '0 : TimeW'(sched - x);
    end else if (r <= 8) begin
      x = sched + 64'($urandom_range(0, 32'(spread)));
      now = (x > 64'(TimeMax)) ? TimeMax : x[TimeW-1:0];
    end else begin
      now = {8'($urandom), 32'($urandom)};
    end
    r = $urandom_range(0, 9);
    if (r < 5) begin
      pend = PendW'($urandom_range(0, 1));
    end else if (r < 8) begin
      pend = PendW'($urandom_range(2, 8));
    end else begin
      pend = PendW'($urandom);
    end
  endtask

  initial begin
    logic [TimeW-1:0] ft, now;
    logic [PendW-1:0] pend;
    logic [GapW-1:0] lim;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    frame_ch.valid = 1'b0;
    frame_ch.frame_time_us = '0;
    frame_ch.now_us = '0;
    frame_ch.pending_frames = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumPlan; i++) begin
      offer_frame(Plan[i].ft, Plan[i].now, Plan[i].pend, Plan[i].typed, Plan[i].want);
      sender_pause(1'b1);
    end
    frame_ch.valid <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: lim = 24'hFFFFFF;
        1: lim = 24'd1;
        2: lim = 24'd33333;
        3: lim = GapW'($urandom_range(1, 24'hFFFFFF));
        4: lim = 24'd255;
        default: lim = MaxGapRst;
      endcase
      write_max_gap(lim);
      if (p == PressurePhase) begin
        hold_off_req = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) begin
        draw_frame(ft, now, pend);
        offer_frame(ft, now, pend, 1'b0, '0);
        sender_pause(!(p == PressurePhase && n < 100));
      end
      frame_ch.valid <= 1'b0;
    end

    while (predicted_releases.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d frames over %0d gap limits (1 to 16777215 us), %0d-cycle output stall",
             frames_sent, limits_written, HoldOff);
    $display("words: %0d rejected, %0d on schedule, %0d catching up, %0d late",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : release_stall
    ready_mode_e mode;
    int unsigned run;
    release_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        release_ch.ready <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end
      mode = ready_mode_e'($urandom_range(0, 3));
      run = $urandom_range(4, 60);
      repeat (run) begin
        case (mode)
          RdyOpen:   release_ch.ready <= 1'b1;
          RdyMostly: release_ch.ready <= ($urandom_range(0, 3) != 0);
          RdyHalf:   release_ch.ready <= 1'($urandom_range(0, 1));
          default:   release_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_releases
    pace_word_t want;
    if (rst_ni && release_ch.valid && release_ch.ready) begin
      status_seen[release_ch.status]++;
      if (predicted_releases.size() == 0) begin
        $display("%0t unexpected word: status %0d wait %0d period %0d", $time,
                 release_ch.status, release_ch.wait_us, release_ch.smoothed_period);
        mismatches++;
      end else begin
        want = predicted_releases.pop_front();
        if (release_ch.status !== want.status) begin
          $display("%0t status: expected %0d, got %0d", $time, want.status,
                   release_ch.status);
          mismatches++;
        end
        if (release_ch.wait_us !== want.wait_us) begin
          $display("%0t wait_us: expected %0d, got %0d", $time, want.wait_us,
                   release_ch.wait_us);
          mismatches++;
        end
        if (release_ch.smoothed_period !== want.period) begin
          $display("%0t smoothed_period: expected %0d, got %0d", $time, want.period,
                   release_ch.smoothed_period);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == Limit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               predicted_releases.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

/* frame_pacing_scheduler_top.f */
+incdir+rtl/core
rtl/core/fps_pkg.sv
rtl/core/fps_if.sv
rtl/core/fps_div.sv
rtl/core/frame_pacing_scheduler_top.sv
test/tb.sv
